// ===== rtl/ptt_pkg.sv =====
// ptt_pkg: types, codes and constants shared by the periodic timer table
// and its port checker. No dependencies.
package ptt_pkg;

   localparam int NUM_TIMERS_DEFAULT = 16;
   localparam int TIME_W = 48;
   localparam int ID_W = 32;
   localparam int IVAL_W = 32;

   localparam logic [TIME_W-1:0] NO_TIMER_WAIT = 48'hFFFF_FFFF_FFFF;

   // request codes
   localparam logic [1:0] REQ_ADD = 2'd0;
   localparam logic [1:0] REQ_DELETE = 2'd1;
   localparam logic [1:0] REQ_TICK = 2'd2;
   localparam logic [1:0] REQ_QUERY = 2'd3;

   // result kinds
   localparam logic [2:0] KIND_ADD = 3'd0;
   localparam logic [2:0] KIND_DELETE = 3'd1;
   localparam logic [2:0] KIND_FIRED = 3'd2;
   localparam logic [2:0] KIND_WAIT = 3'd3;
   localparam logic [2:0] KIND_TICK_END = 3'd4;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [TIME_W-1:0] now_ms;
      logic [IVAL_W-1:0] interval_ms;
      logic [ID_W-1:0]   timer_id;
   } ptt_request_type;

   typedef struct packed {
      logic [2:0]        result_kind;
      logic [ID_W-1:0]   result_id;
      logic [TIME_W-1:0] wait_ms;
      logic              last;
   } ptt_response_type;

   // one timer slot as held in the slot memory
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [IVAL_W-1:0] interval;
      logic [TIME_W-1:0] last_fire;
   } ptt_slot_type;

endpackage

// ===== rtl/periodic_timer_table_top.sv =====
// periodic_timer_table_top: table of periodic timers with add, delete, tick and
// query requests. Depends on ptt_pkg and ptt_ram.
//
// A request is taken at a clock edge where start is high and busy is low; busy
// then stays high until the final result of that request has been put out.
// Results appear on rsp_data for exactly one cycle each, flagged by rsp_strobe,
// and the receiver must take them as they come. Add, delete and query sweep the
// slot memory once with a single read port feeding a three-stage compare
// pipeline; an add with a zero interval is answered without a sweep. A tick
// runs one sweep per fired timer plus one closing sweep, each sweep picking
// the lowest outstanding id. Slot contents are held in a RAM without reset;
// only the valid and fire bits are flops, so no clearing pass is needed after
// reset.
module periodic_timer_table_top import ptt_pkg::*; #(
   parameter int NUM_TIMERS = NUM_TIMERS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ptt_request_type  req_data,
   output logic             rsp_strobe,
   output ptt_response_type rsp_data
);

   localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CW = $clog2(NUM_TIMERS + 1);
   localparam int SLOT_W = $bits(ptt_slot_type);

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_FIN = 2'd2;

   // control state
   logic [1:0]            state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  mark_ff, mark_in;
   logic                  p1_v_ff, p1_v_in;
   logic                  p2_v_ff, p3_v_ff;
   logic [NUM_TIMERS-1:0] valid_ff, valid_in;
   logic [NUM_TIMERS-1:0] fire_ff, fire_in;
   logic [ID_W-1:0]       id_counter_ff, id_counter_in;
   logic                  match_found_ff, match_found_in;
   logic                  free_found_ff, free_found_in;
   logic                  best_found_ff, best_found_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;

   // latched request
   logic [1:0]        op_ff, op_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [IVAL_W-1:0] iv_ff, iv_in;
   logic [ID_W-1:0]   key_ff, key_in;

   // sweep accumulators
   logic [IW-1:0]     match_idx_ff, match_idx_in;
   logic [IW-1:0]     free_idx_ff, free_idx_in;
   logic [IW-1:0]     best_idx_ff, best_idx_in;
   logic [ID_W-1:0]   best_id_ff, best_id_in;
   logic [IVAL_W-1:0] best_iv_ff, best_iv_in;
   logic [TIME_W-1:0] best_wait_ff, best_wait_in;

   ptt_response_type rsp_data_ff, rsp_data_in;

   // compare pipeline
   logic [IW-1:0]     p1_idx_ff, p2_idx_ff, p3_idx_ff;
   logic [TIME_W-1:0] p2_ahead_ff, p2_back_ff;
   logic              p2_borrow_ff, p2_eq_ff;
   logic [ID_W-1:0]   p2_id_ff, p3_id_ff;
   logic [IVAL_W-1:0] p2_iv_ff, p3_iv_ff;
   logic [TIME_W-1:0] p3_wait_ff;
   logic              p3_due_ff, p3_eq_ff;

   // memory ports
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   ptt_slot_type  wr_slot;
   ptt_slot_type  rd_slot;
   logic [SLOT_W-1:0] rd_bits;

   ptt_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (NUM_TIMERS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_slot),
      .rd_addr (cnt_ff[IW-1:0]),
      .rd_data (rd_bits)
   );

   assign rd_slot = ptt_slot_type'(rd_bits);

   // stage 1: elapsed time both ways and id match, from the memory read
   logic [TIME_W:0] diff1;
   logic [TIME_W-1:0] back1;
   logic eq1;

   assign diff1 = {1'b0, now_ff} - {1'b0, rd_slot.last_fire};
   assign back1 = rd_slot.last_fire - now_ff;
   assign eq1 = (rd_slot.id == key_ff);

   // stage 2: due flag and remaining wait
   logic              due2;
   logic [TIME_W-1:0] fwd_wait2, bwd_wait2, wait2;
   logic [TIME_W:0]   sum2;
   logic [IVAL_W-1:0] rem2;

   always_comb begin
      due2 = !p2_borrow_ff && (p2_ahead_ff >= {{(TIME_W-IVAL_W){1'b0}}, p2_iv_ff});
      rem2 = p2_iv_ff - p2_ahead_ff[IVAL_W-1:0];
      fwd_wait2 = due2 ? '0 : {{(TIME_W-IVAL_W){1'b0}}, rem2};
      // time went backwards: interval plus the gap, saturated
      sum2 = {1'b0, p2_back_ff} + {{(TIME_W-IVAL_W+1){1'b0}}, p2_iv_ff};
      bwd_wait2 = sum2[TIME_W] ? NO_TIMER_WAIT : sum2[TIME_W-1:0];
      wait2 = p2_borrow_ff ? bwd_wait2 : fwd_wait2;
   end

   always_ff @(posedge clock) begin
      p1_idx_ff <= cnt_ff[IW-1:0];
      p2_idx_ff <= p1_idx_ff;
      p2_ahead_ff <= diff1[TIME_W-1:0];
      p2_back_ff <= back1;
      p2_borrow_ff <= diff1[TIME_W];
      p2_eq_ff <= eq1;
      p2_id_ff <= rd_slot.id;
      p2_iv_ff <= rd_slot.interval;
      p3_idx_ff <= p2_idx_ff;
      p3_wait_ff <= wait2;
      p3_due_ff <= due2;
      p3_eq_ff <= p2_eq_ff;
      p3_id_ff <= p2_id_ff;
      p3_iv_ff <= p2_iv_ff;
   end

   // sequencer
   logic          p3_slot_valid;
   logic          cand;
   logic [ID_W-1:0] next_id;
   logic [IW-1:0] pick;

   assign p3_slot_valid = valid_ff[p3_idx_ff];
   // id counter wraps and skips zero
   assign next_id = (id_counter_ff == '1) ? ID_W'(1) : id_counter_ff + ID_W'(1);

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      mark_in = mark_ff;
      p1_v_in = 1'b0;
      valid_in = valid_ff;
      fire_in = fire_ff;
      id_counter_in = id_counter_ff;
      match_found_in = match_found_ff;
      free_found_in = free_found_ff;
      best_found_in = best_found_ff;
      op_in = op_ff;
      now_in = now_ff;
      iv_in = iv_ff;
      key_in = key_ff;
      match_idx_in = match_idx_ff;
      free_idx_in = free_idx_ff;
      best_idx_in = best_idx_ff;
      best_id_in = best_id_ff;
      best_iv_in = best_iv_ff;
      best_wait_in = best_wait_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in = '0;
      wr_en = 1'b0;
      wr_addr = best_idx_ff;
      wr_slot.id = best_id_ff;
      wr_slot.interval = best_iv_ff;
      wr_slot.last_fire = now_ff;
      cand = 1'b0;
      pick = match_found_ff ? match_idx_ff : free_idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in = req_data.req_type;
               now_in = req_data.now_ms;
               iv_in = req_data.interval_ms;
               key_in = (req_data.req_type == REQ_ADD) ? next_id : req_data.timer_id;
               cnt_in = '0;
               mark_in = 1'b1;
               match_found_in = 1'b0;
               free_found_in = 1'b0;
               best_found_in = 1'b0;
               best_wait_in = NO_TIMER_WAIT;
               // a zero-interval add is rejected without a sweep
               if (req_data.req_type == REQ_ADD && req_data.interval_ms == '0) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // issue one slot read per cycle
            if (cnt_ff != CW'(NUM_TIMERS)) begin
               p1_v_in = 1'b1;
               cnt_in = cnt_ff + CW'(1);
            end else if (!p1_v_ff && !p2_v_ff && !p3_v_ff) begin
               state_in = ST_FIN;
            end

            // fold in the slot leaving the pipeline
            if (p3_v_ff) begin
               unique case (op_ff)
                  REQ_ADD: begin
                     if (p3_slot_valid && p3_eq_ff && !match_found_ff) begin
                        match_found_in = 1'b1;
                        match_idx_in = p3_idx_ff;
                     end
                     if (!p3_slot_valid && !free_found_ff) begin
                        free_found_in = 1'b1;
                        free_idx_in = p3_idx_ff;
                     end
                  end
                  REQ_DELETE: begin
                     if (p3_slot_valid && p3_eq_ff) begin
                        valid_in[p3_idx_ff] = 1'b0;
                     end
                  end
                  REQ_TICK: begin
                     // first sweep marks due timers, later sweeps pick among marks
                     if (mark_ff) begin
                        cand = p3_slot_valid && p3_due_ff;
                        fire_in[p3_idx_ff] = cand;
                     end else begin
                        cand = fire_ff[p3_idx_ff];
                     end
                     if (cand && (!best_found_ff || p3_id_ff < best_id_ff)) begin
                        best_found_in = 1'b1;
                        best_idx_in = p3_idx_ff;
                        best_id_in = p3_id_ff;
                        best_iv_in = p3_iv_ff;
                     end
                  end
                  REQ_QUERY: begin
                     if (p3_slot_valid && p3_wait_ff < best_wait_ff) begin
                        best_wait_in = p3_wait_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_FIN: begin
            rsp_strobe_in = 1'b1;
            rsp_data_in.last = 1'b1;
            state_in = ST_IDLE;
            unique case (op_ff)
               REQ_ADD: begin
                  rsp_data_in.result_kind = KIND_ADD;
                  if (iv_ff != '0 && (match_found_ff || free_found_ff)) begin
                     // reuse a live slot holding the new id, else lowest free slot
                     wr_en = 1'b1;
                     wr_addr = pick;
                     wr_slot.id = key_ff;
                     wr_slot.interval = iv_ff;
                     valid_in[pick] = 1'b1;
                     id_counter_in = key_ff;
                     rsp_data_in.result_id = key_ff;
                  end
               end
               REQ_DELETE: begin
                  rsp_data_in.result_kind = KIND_DELETE;
               end
               REQ_TICK: begin
                  if (best_found_ff) begin
                     // fire the lowest id, restamp it, then sweep again
                     wr_en = 1'b1;
                     fire_in[best_idx_ff] = 1'b0;
                     rsp_data_in.result_kind = KIND_FIRED;
                     rsp_data_in.result_id = best_id_ff;
                     rsp_data_in.last = 1'b0;
                     state_in = ST_SCAN;
                     cnt_in = '0;
                     mark_in = 1'b0;
                     best_found_in = 1'b0;
                  end else begin
                     rsp_data_in.result_kind = KIND_TICK_END;
                  end
               end
               REQ_QUERY: begin
                  rsp_data_in.result_kind = KIND_WAIT;
                  rsp_data_in.wait_ms = best_wait_ff;
               end
               default: begin
               end
            endcase
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         mark_ff <= 1'b0;
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         valid_ff <= '0;
         fire_ff <= '0;
         id_counter_ff <= '0;
         match_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         mark_ff <= mark_in;
         p1_v_ff <= p1_v_in;
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
         valid_ff <= valid_in;
         fire_ff <= fire_in;
         id_counter_ff <= id_counter_in;
         match_found_ff <= match_found_in;
         free_found_ff <= free_found_in;
         best_found_ff <= best_found_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff <= op_in;
      now_ff <= now_in;
      iv_ff <= iv_in;
      key_ff <= key_in;
      match_idx_ff <= match_idx_in;
      free_idx_ff <= free_idx_in;
      best_idx_ff <= best_idx_in;
      best_id_ff <= best_id_in;
      best_iv_ff <= best_iv_in;
      best_wait_ff <= best_wait_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// ===== rtl/ptt_ram.sv =====
// ptt_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module ptt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ptt_checker.sv =====
// ptt_checker: port-level assertions for the periodic timer table, bound to
// periodic_timer_table_top. Depends on ptt_pkg.
module ptt_checker import ptt_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input ptt_response_type rsp_data
);

   // a taken request keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after request transfer");

   // more results still follow a non-final one
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |-> busy)
      else $error("block idle while results are still due");

   // the final result frees the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last |-> !busy)
      else $error("block still busy at final result");

   // only a fired timer is a non-final result
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_data.result_kind == KIND_FIRED) != rsp_data.last))
      else $error("last flag does not match result kind");

   // wait field is zero except on a wait answer
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.result_kind != KIND_WAIT |-> rsp_data.wait_ms == '0)
      else $error("wait field set on a non-wait result");

endmodule

bind periodic_timer_table_top ptt_checker u_ptt_checker (.*);
